[design/region_stats_and_adjacency_macros.svh]
// Assertion macros shared by the region statistics design files.
// Needs signals clk and arst_n in the scope of each use.
`ifndef REGION_STATS_AND_ADJACENCY_MACROS_SVH
`define REGION_STATS_AND_ADJACENCY_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define RSA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its cause.
`define RSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/rsa_pkg.sv]
// Shared types and constants for the region statistics and adjacency block.
// No dependencies.
package rsa_pkg;

	localparam int unsigned MAX_LABELS_DEF = 64;
	localparam int unsigned MAX_WIDTH_DEF  = 1024;
	localparam int unsigned MAX_HEIGHT_DEF = 1024;

	localparam int unsigned CFG_W        = 11;
	localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd320;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd240;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam int unsigned LABEL_W  = 6;
	localparam int unsigned COUNT_W  = 21;
	localparam int unsigned COLOR_W  = 12;
	localparam int unsigned POS_W    = 14;
	localparam int unsigned ROW_W    = 64;
	localparam int unsigned IN_TDATA_W  = 32;
	localparam int unsigned OUT_TDATA_W = 224;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PIX_RD,
		ST_UP,
		ST_LEFT,
		ST_OUT_RD,
		ST_OUT_LOAD,
		ST_OUT_DIV,
		ST_OUT_SEND
	} state_t;

endpackage

[design/rsa_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read of an address written in the same cycle returns the old data. No dependencies.
module rsa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[design/region_stats_and_adjacency.sv]
// Region statistics and adjacency top level.
// Depends on rsa_pkg, rsa_ram and region_stats_and_adjacency_macros.svh.
//
// Pixels enter in raster order on the slave stream, one item per pixel, and
// each pixel passes through accept and the updates of its own label entry,
// of the entry of the label above and of the entry of the label to the left
// before the next is taken; this order is set by the single read and single
// write port of the label memory, which holds count, color sums, position
// sums and both adjacency rows of every label in one entry. Adjacency is
// recorded only at pixels with x >= 1 and y >= 1. After the last pixel of a
// frame the block emits one item per label from 0 to the largest label seen,
// each held until m_tready; a one-bit-per-cycle divider runs the five means
// side by side for QB = 4 + max(8, log2(MAX_WIDTH), log2(MAX_HEIGHT))
// quotient bits, 14 by default. The last label item carries m_tlast. Labels
// of MAX_LABELS or more are saturated to MAX_LABELS - 1. Label entries have
// per-label valid flops cleared at reset and once the last label item leaves,
// so no clearing pass is needed. image_width and image_height are clamped
// to 2..MAX_WIDTH and 2..MAX_HEIGHT; write them only while the block is idle.
`include "region_stats_and_adjacency_macros.svh"

module region_stats_and_adjacency #(
	parameter int unsigned MAX_LABELS = rsa_pkg::MAX_LABELS_DEF,
	parameter int unsigned MAX_WIDTH  = rsa_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = rsa_pkg::MAX_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic                             cfg_index,
	input  logic [rsa_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// blue[7:0], green[15:8], red[23:16], region_label[29:24], zero pad
	input  logic [rsa_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// region_index[5:0], pixel_count[26:6], mean_blue[38:27], mean_green[50:39],
	// mean_red[62:51], mean_column[76:63], mean_row[90:77],
	// vertical_neighbors[154:91], horizontal_neighbors[218:155], zero pad
	output logic [rsa_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// last_region
	output logic                             m_tlast
);

	localparam int unsigned LB   = $clog2(MAX_LABELS);
	localparam int unsigned ML   = MAX_LABELS;
	localparam int unsigned XB   = $clog2(MAX_WIDTH);
	localparam int unsigned YB   = $clog2(MAX_HEIGHT);
	localparam int unsigned CNTB = XB + YB + 1;
	localparam int unsigned CSW  = CNTB + 8;
	localparam int unsigned XSW  = CNTB + XB;
	localparam int unsigned YSW  = CNTB + YB;
	localparam int unsigned DIMW = (XB + 1 > rsa_pkg::CFG_W) ? XB + 1 :
		((YB + 1 > rsa_pkg::CFG_W) ? YB + 1 : rsa_pkg::CFG_W);
	localparam int unsigned QBM  = (XB > YB) ? XB : YB;
	localparam int unsigned QB   = ((QBM > 8) ? QBM : 8) + 4;
	localparam int unsigned SMAX = (XSW > YSW) ? XSW : YSW;
	localparam int unsigned DW   = ((SMAX > CSW) ? SMAX : CSW) + 4;
	localparam int unsigned SB   = $clog2(QB + 1);
	localparam int unsigned NL   = 5;

	// label entry layout, lowest field first
	localparam int unsigned CNT_LO = 0;
	localparam int unsigned CB_LO  = CNT_LO + CNTB;
	localparam int unsigned CG_LO  = CB_LO + CSW;
	localparam int unsigned CR_LO  = CG_LO + CSW;
	localparam int unsigned PX_LO  = CR_LO + CSW;
	localparam int unsigned PY_LO  = PX_LO + XSW;
	localparam int unsigned VA_LO  = PY_LO + YSW;
	localparam int unsigned HA_LO  = VA_LO + ML;
	localparam int unsigned EW     = HA_LO + ML;

	rsa_pkg::state_t state_q, state_d;

	// configuration
	logic [rsa_pkg::CFG_W-1:0] width_q, height_q;
	logic [DIMW-1:0] w_ext, h_ext, w_eff, h_eff;

	// frame state
	logic [XB-1:0] col_q;
	logic [YB-1:0] row_q;
	logic [LB-1:0] left_q, largest_q;
	logic [ML-1:0] valid_q;

	// pixel pipeline
	logic [LB-1:0] lab_in;
	logic [7:0]    blue_s1, green_s1, red_s1;
	logic [LB-1:0] lab_s1, left_s1;
	logic [XB-1:0] x_s1;
	logic [YB-1:0] y_s1;
	logic          test_s1, frame_end_s1;
	logic [LB-1:0] up_s2;
	logic          vlink_s2, hlink_s2;
	logic [EW-1:0] fwd_s3;
	logic          wrote_up_s3;
	logic          row_end, frame_end;

	// memories
	logic          lm_we;
	logic [LB-1:0] lm_waddr, lm_raddr;
	logic [EW-1:0] lm_wdata, lm_rdata, lm_entry;
	logic          lm_rvalid_q;
	logic [LB-1:0] rb_rdata, up_sat;
	logic [EW-1:0] pix_entry, up_entry, left_entry;

	// output and divider
	logic [LB-1:0]   out_idx_q;
	logic [CNTB-1:0] out_cnt_q;
	logic [ML-1:0]   out_vert_q, out_horz_q;
	logic [CNTB-1:0] rem_q [NL];
	logic [QB-1:0]   quo_q [NL];
	logic [CNTB-1:0] rem_nx [NL];
	logic [QB-1:0]   quo_nx [NL];
	logic [DW-1:0]   dvd [NL];
	logic [SB-1:0]   step_q;
	logic            accept, out_take, out_done;
	logic [QB-1:0]   mean_q [NL];

	assign accept   = s_tvalid && s_tready;
	assign out_take = m_tvalid && m_tready;
	assign out_done = out_take && (out_idx_q == largest_q);

	// clamp geometry to 2..MAX
	assign w_ext = DIMW'(width_q);
	assign h_ext = DIMW'(height_q);
	always_comb begin
		if (w_ext < DIMW'(2)) begin
			w_eff = DIMW'(2);
		end else if (w_ext > DIMW'(MAX_WIDTH)) begin
			w_eff = DIMW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		if (h_ext < DIMW'(2)) begin
			h_eff = DIMW'(2);
		end else if (h_ext > DIMW'(MAX_HEIGHT)) begin
			h_eff = DIMW'(MAX_HEIGHT);
		end else begin
			h_eff = h_ext;
		end
	end

	assign row_end   = (DIMW'(col_q) + DIMW'(1)) >= w_eff;
	assign frame_end = row_end && ((DIMW'(row_q) + DIMW'(1)) >= h_eff);

	// saturate oversized labels
	always_comb begin
		if ((LB + 1)'(s_tdata[29:24]) >= (LB + 1)'(ML)) begin
			lab_in = LB'(ML - 1);
		end else begin
			lab_in = LB'(s_tdata[29:24]);
		end
		if ((LB + 1)'(rb_rdata) >= (LB + 1)'(ML)) begin
			up_sat = LB'(ML - 1);
		end else begin
			up_sat = rb_rdata;
		end
	end

	// an entry never written this frame reads as zero
	assign lm_entry = lm_rvalid_q ? lm_rdata : '0;

	always_comb begin
		pix_entry = lm_entry;
		pix_entry[CNT_LO +: CNTB] = lm_entry[CNT_LO +: CNTB] + CNTB'(1);
		pix_entry[CB_LO +: CSW] = lm_entry[CB_LO +: CSW] + CSW'(blue_s1);
		pix_entry[CG_LO +: CSW] = lm_entry[CG_LO +: CSW] + CSW'(green_s1);
		pix_entry[CR_LO +: CSW] = lm_entry[CR_LO +: CSW] + CSW'(red_s1);
		pix_entry[PX_LO +: XSW] = lm_entry[PX_LO +: XSW] + XSW'(x_s1);
		pix_entry[PY_LO +: YSW] = lm_entry[PY_LO +: YSW] + YSW'(y_s1);
		if (test_s1 && (up_sat != lab_s1)) begin
			pix_entry[VA_LO + up_sat] = 1'b1;
		end
		if (test_s1 && (left_s1 != lab_s1)) begin
			pix_entry[HA_LO + left_s1] = 1'b1;
		end
		up_entry = lm_entry;
		up_entry[VA_LO + lab_s1] = 1'b1;
		// the up row may have just been written when left and up match
		left_entry = (wrote_up_s3 && (left_s1 == up_s2)) ? fwd_s3 : lm_entry;
		left_entry[HA_LO + lab_s1] = 1'b1;
	end

	// label memory port control
	always_comb begin
		lm_we    = 1'b0;
		lm_waddr = lab_s1;
		lm_wdata = pix_entry;
		lm_raddr = out_idx_q;
		case (state_q)
			rsa_pkg::ST_IDLE: begin
				lm_raddr = lab_in;
			end
			rsa_pkg::ST_PIX_RD: begin
				lm_we    = 1'b1;
				lm_raddr = up_sat;
			end
			rsa_pkg::ST_UP: begin
				lm_we    = vlink_s2;
				lm_waddr = up_s2;
				lm_wdata = up_entry;
				lm_raddr = left_s1;
			end
			rsa_pkg::ST_LEFT: begin
				lm_we    = hlink_s2;
				lm_waddr = left_s1;
				lm_wdata = left_entry;
			end
			default: begin
				lm_raddr = out_idx_q;
			end
		endcase
	end

	rsa_ram #(
		.WIDTH(EW),
		.DEPTH(ML)
	) u_label_ram (
		.clk    (clk),
		.wr_en  (lm_we),
		.wr_addr(lm_waddr),
		.wr_data(lm_wdata),
		.rd_addr(lm_raddr),
		.rd_data(lm_rdata)
	);

	// labels of the previous row, indexed by column
	rsa_ram #(
		.WIDTH(LB),
		.DEPTH(MAX_WIDTH)
	) u_row_ram (
		.clk    (clk),
		.wr_en  (state_q == rsa_pkg::ST_PIX_RD),
		.wr_addr(x_s1),
		.wr_data(lab_s1),
		.rd_addr(col_q),
		.rd_data(rb_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rsa_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = rsa_pkg::ST_PIX_RD;
				end
			end
			rsa_pkg::ST_PIX_RD: state_d = rsa_pkg::ST_UP;
			rsa_pkg::ST_UP:     state_d = rsa_pkg::ST_LEFT;
			rsa_pkg::ST_LEFT: begin
				state_d = frame_end_s1 ? rsa_pkg::ST_OUT_RD : rsa_pkg::ST_IDLE;
			end
			rsa_pkg::ST_OUT_RD:   state_d = rsa_pkg::ST_OUT_LOAD;
			rsa_pkg::ST_OUT_LOAD: state_d = rsa_pkg::ST_OUT_DIV;
			rsa_pkg::ST_OUT_DIV: begin
				if (step_q == SB'(1)) begin
					state_d = rsa_pkg::ST_OUT_SEND;
				end
			end
			rsa_pkg::ST_OUT_SEND: begin
				if (out_done) begin
					state_d = rsa_pkg::ST_IDLE;
				end else if (out_take) begin
					state_d = rsa_pkg::ST_OUT_RD;
				end
			end
			default: state_d = rsa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration, counters and valid flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= rsa_pkg::WIDTH_RST;
			height_q    <= rsa_pkg::HEIGHT_RST;
			col_q       <= '0;
			row_q       <= '0;
			left_q      <= '0;
			largest_q   <= '0;
			valid_q     <= '0;
			lm_rvalid_q <= 1'b0;
			out_idx_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == rsa_pkg::REG_IMAGE_WIDTH) begin
					width_q <= cfg_data;
				end
				if (cfg_index == rsa_pkg::REG_IMAGE_HEIGHT) begin
					height_q <= cfg_data;
				end
			end
			lm_rvalid_q <= valid_q[lm_raddr];
			if (lm_we) begin
				valid_q[lm_waddr] <= 1'b1;
			end
			if (accept) begin
				left_q <= lab_in;
				if (lab_in > largest_q) begin
					largest_q <= lab_in;
				end
				if (row_end) begin
					col_q <= '0;
					row_q <= frame_end ? '0 : row_q + YB'(1);
				end else begin
					col_q <= col_q + XB'(1);
				end
			end
			if (state_q == rsa_pkg::ST_LEFT) begin
				out_idx_q <= '0;
			end
			if (out_take) begin
				out_idx_q <= out_idx_q + LB'(1);
			end
			// drop the frame once the last label item leaves
			if (out_done) begin
				valid_q   <= '0;
				largest_q <= '0;
				left_q    <= '0;
			end
		end
	end

	// pixel pipeline registers
	always_ff @(posedge clk) begin
		if (accept) begin
			blue_s1      <= s_tdata[7:0];
			green_s1     <= s_tdata[15:8];
			red_s1       <= s_tdata[23:16];
			lab_s1       <= lab_in;
			left_s1      <= left_q;
			x_s1         <= col_q;
			y_s1         <= row_q;
			test_s1      <= (col_q != '0) && (row_q != '0);
			frame_end_s1 <= frame_end;
		end
		if (state_q == rsa_pkg::ST_PIX_RD) begin
			up_s2    <= up_sat;
			vlink_s2 <= test_s1 && (up_sat != lab_s1);
			hlink_s2 <= test_s1 && (left_s1 != lab_s1);
		end
		if (state_q == rsa_pkg::ST_UP) begin
			fwd_s3      <= up_entry;
			wrote_up_s3 <= vlink_s2;
		end
	end

	// divider lanes: blue, green, red, column, row
	always_comb begin
		dvd[0] = DW'({lm_entry[CB_LO +: CSW], 4'b0000});
		dvd[1] = DW'({lm_entry[CG_LO +: CSW], 4'b0000});
		dvd[2] = DW'({lm_entry[CR_LO +: CSW], 4'b0000});
		dvd[3] = DW'({lm_entry[PX_LO +: XSW], 4'b0000});
		dvd[4] = DW'({lm_entry[PY_LO +: YSW], 4'b0000});
	end

	always_comb begin
		logic [CNTB:0] trial;
		for (int k = 0; k < NL; k++) begin
			trial = {rem_q[k], quo_q[k][QB-1]};
			if (trial >= {1'b0, out_cnt_q}) begin
				rem_nx[k] = CNTB'(trial - {1'b0, out_cnt_q});
				quo_nx[k] = {quo_q[k][QB-2:0], 1'b1};
			end else begin
				rem_nx[k] = CNTB'(trial);
				quo_nx[k] = {quo_q[k][QB-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (state_q == rsa_pkg::ST_OUT_LOAD) begin
			step_q <= SB'(QB);
		end else if (state_q == rsa_pkg::ST_OUT_DIV) begin
			step_q <= step_q - SB'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rsa_pkg::ST_OUT_LOAD) begin
			out_cnt_q  <= lm_entry[CNT_LO +: CNTB];
			out_vert_q <= lm_entry[VA_LO +: ML];
			out_horz_q <= lm_entry[HA_LO +: ML];
			for (int k = 0; k < NL; k++) begin
				// quotient fits QB bits, so the high part is below the count
				rem_q[k] <= CNTB'(dvd[k] >> QB);
				quo_q[k] <= QB'(dvd[k]);
			end
		end else if (state_q == rsa_pkg::ST_OUT_DIV) begin
			for (int k = 0; k < NL; k++) begin
				rem_q[k] <= rem_nx[k];
				quo_q[k] <= quo_nx[k];
			end
		end
	end

	// empty label gives zero means
	always_comb begin
		for (int k = 0; k < NL; k++) begin
			mean_q[k] = (out_cnt_q == '0) ? '0 : quo_q[k];
		end
	end

	assign s_tready = (state_q == rsa_pkg::ST_IDLE);
	assign m_tvalid = (state_q == rsa_pkg::ST_OUT_SEND);
	assign m_tlast  = (out_idx_q == largest_q);
	assign m_tdata  = {
		5'b00000,
		rsa_pkg::ROW_W'(out_horz_q),
		rsa_pkg::ROW_W'(out_vert_q),
		rsa_pkg::POS_W'(mean_q[4]),
		rsa_pkg::POS_W'(mean_q[3]),
		rsa_pkg::COLOR_W'(mean_q[2]),
		rsa_pkg::COLOR_W'(mean_q[1]),
		rsa_pkg::COLOR_W'(mean_q[0]),
		rsa_pkg::COUNT_W'(out_cnt_q),
		rsa_pkg::LABEL_W'(out_idx_q)
	};

	`RSA_ASSERT_NEXT(a_accept_to_rd, accept, state_q == rsa_pkg::ST_PIX_RD,
		"accepted pixel did not move to its label update")
	`RSA_ASSERT_NOW(a_phase_excl, m_tvalid, !s_tready,
		"pixel intake open while label items are sent")
	`RSA_ASSERT_NOW(a_idx_bound, m_tvalid, out_idx_q <= largest_q,
		"label item beyond the largest label")
	`RSA_ASSERT_NEXT(a_frame_clear, out_done, (valid_q == '0) && (largest_q == '0),
		"frame state not cleared after last label item")

endmodule
